// ===== src/keypad_code_lock_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Shared property wrappers for the checker of the keypad code lock unit.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH
`define KEYPAD_CODE_LOCK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define KCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock package
// Payload types, register indexes and the key-to-ASCII table.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KEY_COUNT  = 16;
    localparam int CODE_WIDTH = 7;

    typedef logic [KEY_COUNT-1:0]  key_mask_t;
    typedef logic [CODE_WIDTH-1:0] key_code_t;

    typedef struct packed {
        logic [15:0] early_sample;
        logic [15:0] late_sample;
    } kcl_in_t;

    typedef struct packed {
        logic      key_valid;
        key_code_t key_code;
        logic      verdict_valid;
        logic      unlocked;
    } kcl_out_t;

    typedef struct packed {
        key_mask_t debounced;
        logic      key_found;
        key_code_t code;
    } kcl_scan_t;

    typedef logic cfg_index_t;

    localparam cfg_index_t CFG_FIRST_CODE  = 1'b0;
    localparam cfg_index_t CFG_SECOND_CODE = 1'b1;

    localparam key_code_t FIRST_CODE_RESET  = 7'd48;
    localparam key_code_t SECOND_CODE_RESET = 7'd51;

    // bit 0..15: * 0 # D 7 8 9 C 4 5 6 B 1 2 3 A
    localparam key_code_t KEY_ASCII [KEY_COUNT] = '{
        7'd42, 7'd48, 7'd35, 7'd68, 7'd55, 7'd56, 7'd57, 7'd67,
        7'd52, 7'd53, 7'd54, 7'd66, 7'd49, 7'd50, 7'd51, 7'd65
    };

endpackage

// ===== src/kcl_key_scan.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock key scan
// Debounce two snapshots, mask held keys, encode the lowest fresh key.
// ----------------------------------------------------------------------------
module kcl_key_scan (
    input  kcl_pkg::kcl_in_t   sample,
    input  kcl_pkg::key_mask_t held_keys,
    output kcl_pkg::kcl_scan_t scan
);
    import kcl_pkg::*;

    key_mask_t debounced;
    key_mask_t fresh;
    key_code_t code;

    assign debounced = sample.early_sample & sample.late_sample;
    assign fresh     = debounced & ~held_keys;

    always_comb
    begin
        code = '0;
        // lowest index wins: scan down so it is assigned last
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (fresh[k])
            begin
                code = KEY_ASCII[k];
            end
        end
    end

    assign scan.debounced = debounced;
    assign scan.key_found = |fresh;
    assign scan.code      = code;

endmodule

// ===== src/kcl_lock.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock sequencer
// Hold the key history and two-key attempt state, form each result.
// ----------------------------------------------------------------------------
module kcl_lock (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  kcl_pkg::kcl_scan_t scan,
    input  kcl_pkg::key_code_t first_code,
    input  kcl_pkg::key_code_t second_code,
    output kcl_pkg::key_mask_t held_keys,
    output kcl_pkg::kcl_out_t  result
);
    import kcl_pkg::*;

    key_mask_t held_keys_reg;
    key_mask_t held_keys_next;
    logic      awaiting_reg;
    logic      awaiting_next;
    logic      matched_reg;
    logic      matched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keys_reg <= '0;
            awaiting_reg  <= 1'b0;
            matched_reg   <= 1'b0;
        end
        else if (advance)
        begin
            held_keys_reg <= held_keys_next;
            awaiting_reg  <= awaiting_next;
            matched_reg   <= matched_next;
        end
    end

    always_comb
    begin
        held_keys_next        = scan.debounced;
        awaiting_next         = awaiting_reg;
        matched_next          = matched_reg;
        result.key_valid      = scan.key_found;
        result.key_code       = scan.code;
        result.verdict_valid  = 1'b0;
        result.unlocked       = 1'b0;
        if (scan.key_found)
        begin
            if (!awaiting_reg)
            begin
                matched_next  = (scan.code == first_code);
                awaiting_next = 1'b1;
            end
            else
            begin
                // verdict: clear all history
                result.verdict_valid = 1'b1;
                result.unlocked      = matched_reg && (scan.code == second_code);
                held_keys_next       = '0;
                awaiting_next        = 1'b0;
                matched_next         = 1'b0;
            end
        end
    end

    assign held_keys = held_keys_reg;

endmodule

// ===== src/keypad_code_lock_unit.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock unit
// Debounced 4x4 keypad scan with a two-key combination lock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one pair of matrix
//   snapshots per transfer. Output channel (out_valid/out_ready/out_data)
//   returns exactly one result per input transfer, in order.
//   An input transfer lands in the input register; its result is loaded
//   into the result register, which drives out_valid, once that register
//   is empty or being read out.
//   Throughput is one transfer per cycle while out_ready is high, set by
//   the combinational scan and lock update between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register holds the next item; in_ready drops only when both are full
//   and out_ready is low.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   clock edge; the user, not the block, keeps them to no transfer in flight.
//   Reset empties both registers, clears the key history and attempt state,
//   and loads first_code with '0' and second_code with '3'.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kcl_pkg::kcl_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kcl_pkg::kcl_out_t   out_data,
    input  logic                cfg_we,
    input  kcl_pkg::cfg_index_t cfg_index,
    input  kcl_pkg::key_code_t  cfg_data
);
    import kcl_pkg::*;

    kcl_in_t   in_data_reg;
    logic      in_valid_reg;
    kcl_out_t  out_data_reg;
    logic      out_valid_reg;
    key_code_t first_code_reg;
    key_code_t second_code_reg;

    logic      advance;
    key_mask_t held_keys;
    kcl_scan_t scan;
    kcl_out_t  result;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg  <= FIRST_CODE_RESET;
            second_code_reg <= SECOND_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_CODE:  first_code_reg  <= cfg_data;
                CFG_SECOND_CODE: second_code_reg <= cfg_data;
                default:         first_code_reg  <= first_code_reg;
            endcase
        end
    end

    kcl_key_scan u_scan (
        .sample    (in_data_reg),
        .held_keys (held_keys),
        .scan      (scan)
    );

    kcl_lock u_lock (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .scan        (scan),
        .first_code  (first_code_reg),
        .second_code (second_code_reg),
        .held_keys   (held_keys),
        .result      (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/kcl_checker.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock checker
// Port-level properties of the keypad code lock unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_unit_defines.svh"

module kcl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input kcl_pkg::kcl_out_t out_data
);
    import kcl_pkg::*;

    logic out_stalled;
    logic out_no_verdict;
    logic out_verdict;
    logic out_no_key;

    assign out_stalled    = out_valid && !out_ready;
    assign out_no_verdict = out_valid && !out_data.verdict_valid;
    assign out_verdict    = out_valid && out_data.verdict_valid;
    assign out_no_key     = out_valid && !out_data.key_valid;

    `KCL_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable(out_data), "stalled result changed")
    `KCL_ASSERT_NOW(a_unlock_needs_verdict, out_no_verdict, !out_data.unlocked, "unlock w/o verdict")
    `KCL_ASSERT_NOW(a_verdict_needs_key, out_verdict, out_data.key_valid, "verdict w/o fresh key")
    `KCL_ASSERT_NOW(a_idle_code_zero, out_no_key, out_data.key_code == '0, "code w/o fresh key")

endmodule

bind keypad_code_lock_unit kcl_checker u_kcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
